// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, ignored while reset is held.
`define SLB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SLB_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/slb_pkg.sv
// Shared types and constants of the serial link buffer.
package slb_pkg;

  // Input command codes.
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_QUEUE = 2'd1,
    CMD_FETCH = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Sticky error codes.
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_TX_FULL = 2'd1;
  localparam logic [1:0] ERR_TIMEOUT = 2'd2;

  // Flow control and line-ending characters.
  localparam logic [7:0] XON_CHAR  = 8'h11;
  localparam logic [7:0] XOFF_CHAR = 8'h13;
  localparam logic [7:0] CR_CHAR   = 8'h0d;
  localparam logic [7:0] LF_CHAR   = 8'h0a;

  // Widths of the stream payloads.
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

endpackage

// File: rtl/serial_link_buffer_xon_xoff_top.sv
// Serial link buffer with XON/XOFF flow control: transmit and receive stores.
//
// Usage:
//   Input stream (in_*): in_tuser carries the command (tick with receive
//   sample, queue byte, fetch byte); in_tdata carries the byte to queue and
//   the received-byte sample of a tick.
//   Result stream (out_*): one transaction per command, two for a tick that
//   sends LF (CR first with out_tlast low, then LF with out_tlast high).
//   cfg_wen/cfg_wdata write the XON wait limit in ticks; write it only while
//   no result is outstanding.
// Throughput and timing:
//   A result shows on out_tvalid in the cycle after its command is accepted.
//   The block takes one command per cycle while out_tready is high; a tick
//   that sends LF holds the result register for CR and LF. The limit is
//   the single result register, loaded with both stores' registered reads.
// Reset: all indices, the pause state, the error and the result register
//   clear; the wait limit returns to 65535. Store contents are not cleared.
// Stall: while out_tready is low the current result holds and in_tready
//   stays low, so no command is lost.
module serial_link_buffer_xon_xoff_top #(
  parameter int TX_DEPTH = 64,
  parameter int RX_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // Command channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] data_byte, [8] rx_valid, [16:9] rx_byte, [23:17] zero
  input  logic [23:0] in_tdata,
  // [1:0] cmd
  input  logic [1:0]  in_tuser,
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] tx_valid, [8:1] tx_byte, [9] got_valid, [17:10] got_byte,
  // [19:18] error_code, [23:20] zero
  output logic [23:0] out_tdata,
  output logic        out_tlast,
  // Configuration
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata
);

  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int TX_CW = $clog2(TX_DEPTH + 1);
  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int RX_CW = $clog2(RX_DEPTH + 1);

  // Byte stores
  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] rx_mem [RX_DEPTH];

  // Control state
  logic [TX_CW-1:0] tx_fill_r, tx_fill_nxt;
  logic [TX_CW-1:0] tx_sent_r, tx_sent_nxt;
  logic [RX_CW-1:0] rx_fill_r, rx_fill_nxt;
  logic [RX_CW-1:0] rx_taken_r, rx_taken_nxt;
  logic             paused_r, paused_nxt;
  logic [15:0]      wait_r, wait_nxt;
  logic [1:0]       err_r, err_nxt;
  logic [15:0]      limit_r;

  // Result register
  logic             pend_v_r, pend_v_nxt;
  logic             pend_send_r;
  logic             pend_got_r;
  logic [1:0]       pend_err_r;
  logic [7:0]       tx_rd_r;
  logic [7:0]       rx_rd_r;
  logic             phase_r, phase_nxt;

  // Decoded command fields
  slb_pkg::cmd_t    cmd;
  logic [7:0]       data_byte;
  logic             rx_valid;
  logic [7:0]       rx_byte;

  logic             accept;
  logic             pop;
  logic             send;
  logic             got;
  logic             rx_wr;
  logic [RX_AW-1:0] rx_wr_idx;
  logic             tx_wr;
  logic [15:0]      wait_inc;
  logic             split_cr;

  assign cmd       = slb_pkg::cmd_t'(in_tuser);
  assign data_byte = in_tdata[7:0];
  assign rx_valid  = in_tdata[8];
  assign rx_byte   = in_tdata[16:9];

  // Handshakes
  assign split_cr  = pend_send_r && (tx_rd_r == slb_pkg::LF_CHAR) && !phase_r;
  assign out_tvalid = pend_v_r;
  assign out_tlast  = !split_cr;
  assign pop        = out_tvalid && out_tready;
  assign in_tready  = !pend_v_r || (out_tready && out_tlast);
  assign accept     = in_tvalid && in_tready;

  // Drive the result payload
  always_comb begin
    out_tdata        = '0;
    out_tdata[0]     = pend_send_r;
    out_tdata[8:1]   = !pend_send_r ? 8'h00 : (split_cr ? slb_pkg::CR_CHAR : tx_rd_r);
    out_tdata[9]     = pend_got_r;
    out_tdata[17:10] = pend_got_r ? rx_rd_r : 8'h00;
    out_tdata[19:18] = pend_err_r;
  end

  assign wait_inc = (wait_r != 16'hffff) ? wait_r + 16'd1 : wait_r;

  // Compute the next state of one command
  always_comb begin
    tx_fill_nxt  = tx_fill_r;
    tx_sent_nxt  = tx_sent_r;
    rx_fill_nxt  = rx_fill_r;
    rx_taken_nxt = rx_taken_r;
    paused_nxt   = paused_r;
    wait_nxt     = wait_r;
    err_nxt      = err_r;
    send         = 1'b0;
    got          = 1'b0;
    rx_wr        = 1'b0;
    rx_wr_idx    = rx_fill_r[RX_AW-1:0];
    tx_wr        = 1'b0;
    unique case (cmd)
      slb_pkg::CMD_QUEUE: begin
        if (tx_fill_r < TX_CW'(TX_DEPTH)) begin
          tx_wr       = 1'b1;
          tx_fill_nxt = tx_fill_r + TX_CW'(1);
        end else begin
          err_nxt = slb_pkg::ERR_TX_FULL;
        end
      end
      slb_pkg::CMD_FETCH: begin
        if (rx_taken_r < rx_fill_r) begin
          got          = 1'b1;
          rx_taken_nxt = rx_taken_r + RX_CW'(1);
        end
      end
      slb_pkg::CMD_TICK: begin
        rx_wr = rx_valid;
        if (tx_sent_r < tx_fill_r) begin
          if (paused_r) begin
            rx_wr = 1'b0;
            if (rx_valid && rx_byte == slb_pkg::XON_CHAR) begin
              paused_nxt = 1'b0;
              send       = 1'b1;
            end else if (wait_inc >= limit_r) begin
              err_nxt     = slb_pkg::ERR_TIMEOUT;
              paused_nxt  = 1'b0;
              wait_nxt    = 16'd0;
              tx_sent_nxt = tx_sent_r + TX_CW'(1);
            end else begin
              wait_nxt = wait_inc;
            end
          end else if (rx_valid && rx_byte == slb_pkg::XOFF_CHAR) begin
            paused_nxt = 1'b1;
            wait_nxt   = 16'd0;
            rx_wr      = 1'b0;
          end else begin
            send = 1'b1;
          end
        end else begin
          tx_fill_nxt = '0;
          tx_sent_nxt = '0;
          paused_nxt  = 1'b0;
          wait_nxt    = 16'd0;
        end
        if (send) begin
          tx_sent_nxt = tx_sent_r + TX_CW'(1);
        end
        // Rewind an empty receive store, drop a byte when it is full
        if (rx_wr) begin
          if (rx_fill_r == rx_taken_r) begin
            rx_wr_idx    = '0;
            rx_fill_nxt  = RX_CW'(1);
            rx_taken_nxt = '0;
          end else if (rx_fill_r < RX_CW'(RX_DEPTH)) begin
            rx_fill_nxt = rx_fill_r + RX_CW'(1);
          end else begin
            rx_wr = 1'b0;
          end
        end
      end
      slb_pkg::CMD_NONE: begin
      end
      default: begin
      end
    endcase
  end

  // Advance the result register
  always_comb begin
    pend_v_nxt = pend_v_r;
    phase_nxt  = phase_r;
    if (pop) begin
      phase_nxt = !out_tlast;
      if (out_tlast) begin
        pend_v_nxt = 1'b0;
      end
    end
    if (accept) begin
      pend_v_nxt = 1'b1;
      phase_nxt  = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_fill_r  <= '0;
      tx_sent_r  <= '0;
      rx_fill_r  <= '0;
      rx_taken_r <= '0;
      paused_r   <= 1'b0;
      wait_r     <= 16'd0;
      err_r      <= slb_pkg::ERR_NONE;
      limit_r    <= 16'hffff;
      pend_v_r   <= 1'b0;
      phase_r    <= 1'b0;
    end else begin
      if (accept) begin
        tx_fill_r  <= tx_fill_nxt;
        tx_sent_r  <= tx_sent_nxt;
        rx_fill_r  <= rx_fill_nxt;
        rx_taken_r <= rx_taken_nxt;
        paused_r   <= paused_nxt;
        wait_r     <= wait_nxt;
        err_r      <= err_nxt;
      end
      if (cfg_wen) begin
        limit_r <= cfg_wdata;
      end
      pend_v_r <= pend_v_nxt;
      phase_r  <= phase_nxt;
    end
  end

  // Result payload, loaded with each accepted command
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_send_r <= send;
      pend_got_r  <= got;
      pend_err_r  <= err_nxt;
    end
  end

  // Transmit store: write on queue, registered read at the send index
  always_ff @(posedge clk) begin
    if (accept && tx_wr) begin
      tx_mem[tx_fill_r[TX_AW-1:0]] <= data_byte;
    end
    if (accept) begin
      tx_rd_r <= tx_mem[tx_sent_r[TX_AW-1:0]];
    end
  end

  // Receive store: write on sample, registered read at the fetch index
  always_ff @(posedge clk) begin
    if (accept && rx_wr) begin
      rx_mem[rx_wr_idx] <= rx_byte;
    end
    if (accept) begin
      rx_rd_r <= rx_mem[rx_taken_r[RX_AW-1:0]];
    end
  end

endmodule

// File: rtl/slb_checker.sv
// Port-level checker for the serial link buffer, bound to the top level.
`include "assert_macros.svh"

module slb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  // Result register is empty right after reset
  `SLB_ASSERT_RST(a_reset_idle, !rst_n |=> !out_tvalid, "result valid after reset")

  // Hold a stalled transaction
  `SLB_ASSERT(a_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

  // A non-final transaction is always the CR put before LF
  `SLB_ASSERT(a_cr_first, out_tvalid && !out_tlast |-> out_tdata[0] && out_tdata[8:1] == slb_pkg::CR_CHAR, "non-final result is not CR")

  // LF follows its CR at once as the final transaction
  `SLB_ASSERT(a_lf_next, out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tlast && out_tdata[8:1] == slb_pkg::LF_CHAR, "LF does not follow CR")

endmodule

bind serial_link_buffer_xon_xoff_top slb_checker u_slb_checker (.*);

// File: tb/sv/testbench.sv
// Self-checking testbench for the serial link buffer with XON/XOFF flow control.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import slb_pkg::*;

  localparam int TX_DEPTH = 64;
  localparam int RX_DEPTH = 8;
  localparam int PHASE_ITEMS = 265;

  // One command transaction as the stimulus builds it
  typedef struct {
    cmd_t       cmd;
    logic [7:0] data_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
  } link_cmd_t;

  // One result transaction as the block should return it
  typedef struct {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       got_valid;
    logic [7:0] got_byte;
    logic [1:0] error_code;
    logic       last;
  } link_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0]  in_tuser = CMD_NONE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        cfg_wen = 1'b0;
  logic [15:0] cfg_wdata = '0;

  link_cmd_t    cmd_queue[$];
  link_result_t result_queue[$];
  int           mismatch_count = 0;

  // Model copy of the block state
  logic [7:0]  tx_mem [TX_DEPTH];
  logic [6:0]  tx_fill;
  logic [6:0]  tx_sent;
  logic [7:0]  rx_mem [RX_DEPTH];
  logic [3:0]  rx_fill;
  logic [3:0]  rx_taken;
  logic        paused;
  logic [15:0] wait_count;
  logic [1:0]  error_reg;
  logic [15:0] pause_limit;

  // Handshake bookkeeping
  logic      in_fire = 1'b0;
  int        in_gap = 0;
  int        out_stall = 0;
  int        calm_in = 0;
  int        calm_out = 0;
  int        gap_pick;
  link_cmd_t next_cmd;

  serial_link_buffer_xon_xoff_top #(
    .TX_DEPTH(TX_DEPTH),
    .RX_DEPTH(RX_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Queue a result with the current sticky error
  function automatic void push_result(logic txv, logic [7:0] txb, logic gv,
                                      logic [7:0] gb, logic lst);
    link_result_t r;
    r.tx_valid   = txv;
    r.tx_byte    = txb;
    r.got_valid  = gv;
    r.got_byte   = gb;
    r.error_code = error_reg;
    r.last       = lst;
    result_queue.push_back(r);
  endfunction

  // Advance the state model by one command and queue its results
  task automatic predict_link(input link_cmd_t c);
    logic       rx_used;
    logic       send;
    logic       got;
    logic [7:0] b;
    rx_used = 1'b0;
    send    = 1'b0;
    got     = 1'b0;
    b       = 8'h00;
    case (c.cmd)
      CMD_QUEUE: begin
        if (tx_fill < TX_DEPTH) begin
          tx_mem[tx_fill] = c.data_byte;
          tx_fill++;
        end else begin
          error_reg = ERR_TX_FULL;
        end
        push_result(1'b0, 8'h00, 1'b0, 8'h00, 1'b1);
      end
      CMD_FETCH: begin
        if (rx_taken < rx_fill && rx_taken < RX_DEPTH) begin
          b   = rx_mem[rx_taken];
          got = 1'b1;
          rx_taken++;
        end
        push_result(1'b0, 8'h00, got, b, 1'b1);
      end
      CMD_TICK: begin
        if (tx_sent < tx_fill && tx_sent < TX_DEPTH) begin
          if (paused) begin
            rx_used = c.rx_valid;
            if (c.rx_valid && c.rx_byte == XON_CHAR) begin
              paused = 1'b0;
              send   = 1'b1;
            end else begin
              if (wait_count < 16'hffff) wait_count++;
              // give up on the pending byte once the wait limit is hit
              if (wait_count >= pause_limit) begin
                error_reg  = ERR_TIMEOUT;
                paused     = 1'b0;
                wait_count = '0;
                tx_sent++;
              end
            end
          end else if (c.rx_valid && c.rx_byte == XOFF_CHAR) begin
            paused     = 1'b1;
            wait_count = '0;
            rx_used    = 1'b1;
          end else begin
            send = 1'b1;
          end
        end else begin
          tx_fill    = '0;
          tx_sent    = '0;
          paused     = 1'b0;
          wait_count = '0;
        end
        // store the received byte, rewinding an empty store first
        if (c.rx_valid && !rx_used) begin
          if (rx_fill == rx_taken) begin
            rx_fill  = '0;
            rx_taken = '0;
          end
          if (rx_fill < RX_DEPTH) begin
            rx_mem[rx_fill] = c.rx_byte;
            rx_fill++;
          end
        end
        if (send) begin
          b = tx_mem[tx_sent];
          tx_sent++;
          if (b == LF_CHAR) begin
            push_result(1'b1, CR_CHAR, 1'b0, 8'h00, 1'b0);
            push_result(1'b1, LF_CHAR, 1'b0, 8'h00, 1'b1);
          end else begin
            push_result(1'b1, b, 1'b0, 8'h00, 1'b1);
          end
        end else begin
          push_result(1'b0, 8'h00, 1'b0, 8'h00, 1'b1);
        end
      end
      default: push_result(1'b0, 8'h00, 1'b0, 8'h00, 1'b1);
    endcase
  endtask

  task automatic report_field(input string name, input int exp_v, input int act_v);
    $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, exp_v, act_v);
    mismatch_count++;
  endtask

  // Watch both channels and the register write at the rising edge
  always @(posedge clk) begin
    link_result_t exp_r;
    in_fire <= rst_n && in_tvalid && in_tready;
    if (!rst_n) begin
      tx_fill     = '0;
      tx_sent     = '0;
      rx_fill     = '0;
      rx_taken    = '0;
      paused      = 1'b0;
      wait_count  = '0;
      error_reg   = ERR_NONE;
      pause_limit = 16'hffff;
    end else begin
      if (out_tvalid && out_tready) begin
        if (result_queue.size() == 0) begin
          $display("%0t: unexpected result expected none actual 0x%06h last %0b",
                   $time, out_tdata, out_tlast);
          mismatch_count++;
        end else begin
          exp_r = result_queue.pop_front();
          if (out_tdata[0] !== exp_r.tx_valid)
            report_field("tx_valid", exp_r.tx_valid, out_tdata[0]);
          if (out_tdata[8:1] !== exp_r.tx_byte)
            report_field("tx_byte", exp_r.tx_byte, out_tdata[8:1]);
          if (out_tdata[9] !== exp_r.got_valid)
            report_field("got_valid", exp_r.got_valid, out_tdata[9]);
          if (out_tdata[17:10] !== exp_r.got_byte)
            report_field("got_byte", exp_r.got_byte, out_tdata[17:10]);
          if (out_tdata[19:18] !== exp_r.error_code)
            report_field("error_code", exp_r.error_code, out_tdata[19:18]);
          if (out_tlast !== exp_r.last)
            report_field("last", exp_r.last, out_tlast);
        end
      end
      if (in_tvalid && in_tready)
        predict_link('{cmd_t'(in_tuser), in_tdata[7:0], in_tdata[8], in_tdata[16:9]});
      if (cfg_wen) pause_limit = cfg_wdata;
    end
  end

  // Drive commands at the falling edge, holding each until it is taken
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (calm_in > 0) calm_in--;
      else if ($urandom_range(0, 149) == 0) calm_in = $urandom_range(30, 120);
      if (in_gap > 0 || cmd_queue.size() == 0) begin
        in_tvalid <= 1'b0;
        if (in_gap > 0) in_gap--;
      end else begin
        next_cmd  = cmd_queue.pop_front();
        in_tdata  <= {7'b0, next_cmd.rx_byte, next_cmd.rx_valid, next_cmd.data_byte};
        in_tuser  <= next_cmd.cmd;
        in_tvalid <= 1'b1;
        in_gap    = (calm_in > 0) ? 0 : pick_gap();
      end
    end
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    if (calm_out > 0) calm_out--;
    else if ($urandom_range(0, 149) == 0) calm_out = $urandom_range(30, 120);
    if (out_stall > 0) begin
      out_tready <= 1'b0;
      out_stall--;
    end else begin
      gap_pick = (calm_out > 0) ? 0 : pick_gap();
      out_tready <= (gap_pick == 0);
      out_stall = (gap_pick == 0) ? 0 : gap_pick - 1;
    end
  end

  task automatic add_cmd(input cmd_t c, input logic [7:0] d, input logic rxv,
                         input logic [7:0] rxb);
    cmd_queue.push_back('{c, d, rxv, rxb});
  endtask

  // Queue bytes lean toward LF, received bytes toward flow control
  function automatic logic [7:0] pick_data_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return LF_CHAR;
    if (r < 25) return ($urandom_range(0, 1) != 0) ? XON_CHAR : XOFF_CHAR;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_rx_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return XOFF_CHAR;
    if (r < 30) return XON_CHAR;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic wait_drained();
    while (cmd_queue.size() != 0 || in_tvalid || result_queue.size() != 0)
      @(posedge clk);
  endtask

  // Reset, then run phases at several wait limits
  initial begin
    logic [15:0] limits [6];
    int phase_start;
    int n;
    limits = '{16'hffff, 16'd1, 16'd3, 16'($urandom_range(2, 12)), 16'd2,
               16'($urandom_range(1, 65535))};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      repeat (4) @(negedge clk);
      cfg_wen   <= 1'b1;
      cfg_wdata <= limits[p];
      @(negedge clk);
      cfg_wen   <= 1'b0;
      phase_start = cmd_queue.size();
      if (p == 0) begin
        // fetch and idle on empty stores, then the queue byte extremes and LF
        add_cmd(CMD_FETCH, 8'h00, 1'b0, 8'h00);
        add_cmd(CMD_NONE, 8'hff, 1'b1, 8'hff);
        add_cmd(CMD_QUEUE, 8'h00, 1'b0, 8'h00);
        add_cmd(CMD_QUEUE, 8'hff, 1'b0, 8'h00);
        add_cmd(CMD_QUEUE, LF_CHAR, 1'b0, 8'h00);
        add_cmd(CMD_TICK, 8'hff, 1'b0, 8'h00);
        add_cmd(CMD_TICK, 8'h00, 1'b1, 8'hff);
        add_cmd(CMD_TICK, 8'h00, 1'b0, 8'h00);
        add_cmd(CMD_TICK, 8'h00, 1'b0, 8'h00);
        // flow control characters with nothing pending are plain data
        add_cmd(CMD_TICK, 8'h00, 1'b1, XOFF_CHAR);
        add_cmd(CMD_TICK, 8'h00, 1'b1, XON_CHAR);
        add_cmd(CMD_FETCH, 8'h00, 1'b0, 8'h00);
        add_cmd(CMD_FETCH, 8'h00, 1'b0, 8'h00);
        add_cmd(CMD_FETCH, 8'h00, 1'b0, 8'h00);
        add_cmd(CMD_FETCH, 8'h00, 1'b0, 8'h00);
        // pause, drop a byte while paused, resume on XON
        add_cmd(CMD_QUEUE, 8'h41, 1'b0, 8'h00);
        add_cmd(CMD_QUEUE, LF_CHAR, 1'b0, 8'h00);
        add_cmd(CMD_TICK, 8'h00, 1'b1, XOFF_CHAR);
        add_cmd(CMD_TICK, 8'h00, 1'b1, 8'h55);
        add_cmd(CMD_TICK, 8'h00, 1'b1, XON_CHAR);
        add_cmd(CMD_TICK, 8'h00, 1'b0, 8'h00);
        add_cmd(CMD_TICK, 8'h00, 1'b0, 8'h00);
        add_cmd(CMD_FETCH, 8'h00, 1'b0, 8'h00);
      end else if (p == 1) begin
        // time out on the first paused tick
        add_cmd(CMD_QUEUE, 8'h7e, 1'b0, 8'h00);
        add_cmd(CMD_TICK, 8'h00, 1'b1, XOFF_CHAR);
        add_cmd(CMD_TICK, 8'h00, 1'b0, 8'h00);
        add_cmd(CMD_TICK, 8'h00, 1'b0, 8'h00);
      end
      while (cmd_queue.size() - phase_start < PHASE_ITEMS) begin
        case ($urandom_range(0, 3))
          0: begin
            // fill the transmit store, sometimes past full, then drain it
            n = $urandom_range(1, 70);
            repeat (n) add_cmd(CMD_QUEUE, pick_data_byte(), 1'($urandom), 8'($urandom));
            repeat (n + 4)
              add_cmd(CMD_TICK, 8'($urandom),
                      ($urandom_range(0, 4) == 0), 8'($urandom_range(0, 255)));
          end
          1: begin
            // pause with XOFF, idle with line noise, then XON or wait it out
            n = $urandom_range(1, 4);
            repeat (n) add_cmd(CMD_QUEUE, pick_data_byte(), 1'b0, 8'($urandom));
            if ($urandom_range(0, 1) != 0) add_cmd(CMD_TICK, 8'($urandom), 1'b0, 8'h00);
            add_cmd(CMD_TICK, 8'($urandom), 1'b1, XOFF_CHAR);
            repeat ($urandom_range(0, 6))
              add_cmd(CMD_TICK, 8'($urandom), 1'($urandom), 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) < 7) add_cmd(CMD_TICK, 8'($urandom), 1'b1, XON_CHAR);
            repeat (n + 2)
              add_cmd(CMD_TICK, 8'($urandom), ($urandom_range(0, 3) == 0),
                      pick_rx_byte());
          end
          2: begin
            // receive a run of bytes, sometimes past full, then fetch
            repeat ($urandom_range(1, 12))
              add_cmd(CMD_TICK, 8'($urandom), 1'b1, pick_rx_byte());
            repeat ($urandom_range(1, 10))
              add_cmd(CMD_FETCH, 8'($urandom), 1'($urandom), 8'($urandom));
          end
          default: begin
            // unstructured commands
            repeat ($urandom_range(1, 10))
              add_cmd(cmd_t'($urandom_range(0, 3)), pick_data_byte(), 1'($urandom),
                      pick_rx_byte());
          end
        endcase
      end
    end
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
